// ===== sv/skt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types for the sorted key table
// Word layouts for the command and result channels, plus operation,
// status and sequencer state codes.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W    = 64;
  localparam int HANDLE_W = 16;
  localparam int COUNT_W  = 5;
  localparam int POS_W    = 4;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_PUT,
    S_DEL_CMP,
    S_DEL_SHIFT,
    S_DONE
  } state_t;

  typedef struct packed {
    cmd_t                  cmd;
    logic [KEY_W-1:0]      title_key;
    logic [HANDLE_W-1:0]   entry_handle;
  } in_word_t;

  typedef struct packed {
    status_t               status;
    logic [COUNT_W-1:0]    entry_count;
    logic [POS_W-1:0]      position;
  } out_word_t;

endpackage
`default_nettype wire

// ===== sv/sorted_key_table.sv =====
`default_nettype none
// Walk: insert goes down from the top entry, moving larger keys up a slot; delete
//   goes up from entry zero, moving later entries down after a match. A full insert
//   or empty delete skips the walk. One entry per cycle through the memory.
// Throughput: one word at a time; a new word is taken once the result is parked.
// Reset: rst_n synchronous active low clears the entry count and control state;
//   the table memory is not cleared.
// ----------------------------------------------------------------------------
// sorted_key_table: ordered key/handle table
// Keeps up to DEPTH entries in ascending key order in a single-port-write,
// single-port-read memory, walking it one entry per cycle with a shared compare unit.
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int DEPTH     = 16,
  parameter int KEY_BYTES = 8
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire skt_pkg::in_word_t in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output skt_pkg::out_word_t  out_data
);
  import skt_pkg::*;

  localparam int KW = 8 * KEY_BYTES;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [KW-1:0]       key_mem [DEPTH];
  logic [HANDLE_W-1:0] hnd_mem [DEPTH];

  state_t              state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  status_t             res_r, res_nxt;
  cmd_t                cmd_r;
  logic [KW-1:0]       key_r;
  logic [HANDLE_W-1:0] hnd_r;
  logic [KW-1:0]       rd_key_r;
  logic [HANDLE_W-1:0] rd_hnd_r;
  logic                out_valid_r;
  out_word_t           out_data_r;

  logic                rd_en, wr_en;
  logic [AW-1:0]       rd_addr, wr_addr;
  logic [KW-1:0]       wr_key;
  logic [HANDLE_W-1:0] wr_hnd;

  logic                in_fire, slot_free;
  logic                gt, eq, last, full, empty;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared compare unit
  assign gt    = rd_key_r > key_r;
  assign eq    = rd_key_r == key_r;
  assign last  = (CW'(j_r) + CW'(1)) == count_r;
  assign full  = count_r == CW'(DEPTH);
  assign empty = count_r == '0;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data.cmd == CMD_INSERT) begin
            if (full)       state_nxt = S_DONE;
            else if (empty) state_nxt = S_INS_PUT;
            else            state_nxt = S_INS_CMP;
          end else begin
            state_nxt = empty ? S_DONE : S_DEL_CMP;
          end
        end
      end
      S_INS_CMP: begin
        if (!gt)            state_nxt = S_DONE;
        else if (j_r == '0) state_nxt = S_INS_PUT;
      end
      S_INS_PUT: state_nxt = S_DONE;
      S_DEL_CMP: begin
        if (last)    state_nxt = S_DONE;
        else if (eq) state_nxt = S_DEL_SHIFT;
      end
      S_DEL_SHIFT: begin
        if (last) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    rd_addr   = j_r;
    wr_en     = 1'b0;
    wr_addr   = j_r;
    wr_key    = key_r;
    wr_hnd    = hnd_r;
    j_nxt     = j_r;
    pos_nxt   = pos_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt = ST_OK;
          pos_nxt = '0;
          if (in_data.cmd == CMD_INSERT) begin
            if (full) begin
              res_nxt = ST_FULL;
            end else begin
              j_nxt   = AW'(count_r - CW'(1));
              rd_en   = !empty;
              rd_addr = AW'(count_r - CW'(1));
            end
          end else begin
            if (empty) res_nxt = ST_NOT_FOUND;
            j_nxt   = '0;
            rd_en   = !empty;
            rd_addr = '0;
          end
        end
      end
      S_INS_CMP: begin
        wr_en   = 1'b1;
        wr_addr = j_r + AW'(1);
        if (gt) begin
          wr_key  = rd_key_r;
          wr_hnd  = rd_hnd_r;
          j_nxt   = j_r - AW'(1);
          rd_en   = (j_r != '0);
          rd_addr = j_r - AW'(1);
        end else begin
          pos_nxt   = j_r + AW'(1);
          count_nxt = count_r + CW'(1);
        end
      end
      S_INS_PUT: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        pos_nxt   = '0;
        count_nxt = count_r + CW'(1);
      end
      S_DEL_CMP: begin
        rd_en   = !last;
        rd_addr = j_r + AW'(1);
        j_nxt   = j_r + AW'(1);
        if (eq) begin
          pos_nxt = j_r;
          if (last) count_nxt = count_r - CW'(1);
        end else if (last) begin
          res_nxt = ST_NOT_FOUND;
        end
      end
      S_DEL_SHIFT: begin
        wr_en   = 1'b1;
        wr_addr = j_r - AW'(1);
        wr_key  = rd_key_r;
        wr_hnd  = rd_hnd_r;
        rd_en   = !last;
        rd_addr = j_r + AW'(1);
        j_nxt   = j_r + AW'(1);
        if (last) count_nxt = count_r - CW'(1);
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      hnd_mem[wr_addr] <= wr_hnd;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_hnd_r <= hnd_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    pos_r <= pos_nxt;
    res_r <= res_nxt;
    if (in_fire) begin
      cmd_r <= in_data.cmd;
      key_r <= in_data.title_key[KW-1:0];
      hnd_r <= in_data.entry_handle;
    end
    if (state_r == S_DONE && slot_free) begin
      out_data_r.status      <= res_r;
      out_data_r.entry_count <= COUNT_W'(count_r);
      out_data_r.position    <= POS_W'(pos_r);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("accepted a word while busy");

  a_fail_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && res_r != ST_OK) |-> pos_r == '0)
    else $error("failed operation with nonzero position");

  a_delete_only_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DEL_CMP || state_r == S_DEL_SHIFT) |-> cmd_r == CMD_DELETE)
    else $error("delete walk on insert word");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_DONE && count_nxt != count_r) |->
      (count_nxt == count_r + CW'(1) || count_nxt == count_r - CW'(1)))
    else $error("entry count jumped");
`endif

endmodule
`default_nettype wire
